// ----- rtl/i2cm_pkg.sv -----
package i2cm_pkg;

  localparam logic [1:0]  ADDR_RETRIES  = 2'd3;
  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
  localparam logic [15:0] HALF_RESET    = 16'd24;

  // register map, word index
  localparam logic CFG_HALF_PERIOD = 1'b0;

  // request kinds
  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_WRITE1 = 2'd1;
  localparam logic [1:0] REQ_WRITE2 = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_WADDR_NACK  = 2'd1;
  localparam logic [1:0] ST_WDATA_NACK  = 2'd2;
  localparam logic [1:0] ST_RADDR_NACK  = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_TX_LOW,
    PH_TX_HIGH,
    PH_TACK_LOW,
    PH_TACK_HIGH,
    PH_RX_LOW,
    PH_RX_HIGH,
    PH_RACK_LOW,
    PH_RACK_HIGH,
    PH_STOP_LOW,
    PH_STOP_HIGH,
    PH_STOP_END
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] tick_count;
    logic [3:0]  bit_count;
    logic [7:0]  shift_byte;
    logic [1:0]  attempt_count;
    logic [1:0]  req_kind;
    logic [7:0]  req_addr;
    logic [7:0]  req_d1;
    logic [7:0]  req_d2;
    logic [1:0]  byte_index;
    logic [1:0]  last_status;
  } eng_state_t;

  typedef struct packed {
    logic       req_valid;
    logic [1:0] req_type;
    logic [7:0] dev_addr;
    logic [7:0] data_first;
    logic [7:0] data_second;
    logic       sda_in;
    logic       scl_in;
  } tick_item_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
  } tick_res_t;

endpackage

// ----- rtl/i2cm_in_if.sv -----
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic       req_valid;
  logic [1:0] req_type;
  logic [7:0] dev_addr;
  logic [7:0] data_first;
  logic [7:0] data_second;
  logic       sda_in;
  logic       scl_in;

  modport source (
    output valid, req_valid, req_type, dev_addr, data_first, data_second, sda_in, scl_in,
    input  ready
  );
  modport sink (
    input  valid, req_valid, req_type, dev_addr, data_first, data_second, sda_in, scl_in,
    output ready
  );
endinterface

// ----- rtl/i2cm_out_if.sv -----
interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_release;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;
  logic [7:0] read_data;

  modport source (
    output valid, scl_release, sda_release, busy_res, done_res, status, read_data,
    input  ready
  );
  modport sink (
    input  valid, scl_release, sda_release, busy_res, done_res, status, read_data,
    output ready
  );
endinterface

// ----- rtl/i2cm_step.sv -----
module i2cm_step
  import i2cm_pkg::*;
(
  input  eng_state_t  cur,
  input  tick_item_t  item,
  input  logic [15:0] half_period,
  output eng_state_t  nxt,
  output tick_res_t   res
);

  logic [15:0] h_eff;
  logic [15:0] tick_inc;
  logic [3:0]  bit_inc;
  logic [1:0]  attempt_inc;
  logic [7:0]  addr_byte;
  logic        is_read;
  logic        wait_high;
  logic        ack;
  logic        done;
  logic        busy;

  assign h_eff       = (half_period == 16'd0) ? 16'd1 : half_period;
  assign tick_inc    = cur.tick_count + 16'd1;
  assign bit_inc     = cur.bit_count + 4'd1;
  assign attempt_inc = cur.attempt_count + 2'd1;
  assign is_read     = (cur.req_kind == REQ_READ);
  // read sends address plus one, wrapping at 8 bits
  assign addr_byte   = is_read ? cur.req_addr + 8'd1 : cur.req_addr;
  assign ack         = !item.sda_in;

  always_comb begin
    case (cur.phase)
      PH_TX_HIGH, PH_TACK_HIGH, PH_RX_HIGH, PH_RACK_HIGH, PH_STOP_HIGH: wait_high = 1'b1;
      default: wait_high = 1'b0;
    endcase
  end

  always_comb begin
    nxt  = cur;
    done = 1'b0;
    if (cur.phase == PH_IDLE) begin
      if (item.req_valid && item.req_type != REQ_NONE) begin
        nxt.req_kind      = item.req_type;
        nxt.req_addr      = item.dev_addr;
        nxt.req_d1        = item.data_first;
        nxt.req_d2        = item.data_second;
        nxt.attempt_count = 2'd0;
        nxt.byte_index    = 2'd0;
        nxt.bit_count     = 4'd0;
        nxt.last_status   = ST_OK;
        nxt.tick_count    = 16'd0;
        nxt.phase         = PH_START;
      end
    end else if (!(wait_high && !item.scl_in)) begin
      // stretched clock holds the count
      if (tick_inc < h_eff) begin
        nxt.tick_count = tick_inc;
      end else begin
        nxt.tick_count = 16'd0;
        case (cur.phase)
          PH_START: begin
            nxt.shift_byte = addr_byte;
            nxt.bit_count  = 4'd0;
            nxt.phase      = PH_TX_LOW;
          end
          PH_TX_LOW:  nxt.phase = PH_TX_HIGH;
          PH_TX_HIGH: begin
            nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
            nxt.bit_count  = bit_inc;
            nxt.phase      = (bit_inc >= BITS_PER_BYTE) ? PH_TACK_LOW : PH_TX_LOW;
          end
          PH_TACK_LOW: nxt.phase = PH_TACK_HIGH;
          PH_TACK_HIGH: begin
            if (cur.byte_index == 2'd0) begin
              if (ack && is_read) begin
                nxt.shift_byte = 8'd0;
                nxt.bit_count  = 4'd0;
                nxt.phase      = PH_RX_LOW;
              end else if (ack) begin
                nxt.byte_index = 2'd1;
                nxt.shift_byte = cur.req_d1;
                nxt.bit_count  = 4'd0;
                nxt.phase      = PH_TX_LOW;
              end else begin
                nxt.attempt_count = attempt_inc;
                if (attempt_inc >= ADDR_RETRIES) begin
                  nxt.last_status = is_read ? ST_RADDR_NACK : ST_WADDR_NACK;
                  nxt.shift_byte  = 8'd0;
                  nxt.phase       = PH_STOP_LOW;
                end else begin
                  // retry the address without a new start
                  nxt.shift_byte = addr_byte;
                  nxt.bit_count  = 4'd0;
                  nxt.phase      = PH_TX_LOW;
                end
              end
            end else if (!ack) begin
              nxt.last_status = ST_WDATA_NACK;
              nxt.shift_byte  = 8'd0;
              nxt.phase       = PH_STOP_LOW;
            end else if (cur.req_kind == REQ_WRITE2 && cur.byte_index == 2'd1) begin
              nxt.byte_index = 2'd2;
              nxt.shift_byte = cur.req_d2;
              nxt.bit_count  = 4'd0;
              nxt.phase      = PH_TX_LOW;
            end else begin
              nxt.last_status = ST_OK;
              nxt.shift_byte  = 8'd0;
              nxt.phase       = PH_STOP_LOW;
            end
          end
          PH_RX_LOW:  nxt.phase = PH_RX_HIGH;
          PH_RX_HIGH: begin
            nxt.shift_byte = {cur.shift_byte[6:0], item.sda_in};
            nxt.bit_count  = bit_inc;
            nxt.phase      = (bit_inc >= BITS_PER_BYTE) ? PH_RACK_LOW : PH_RX_LOW;
          end
          PH_RACK_LOW:  nxt.phase = PH_RACK_HIGH;
          PH_RACK_HIGH: begin
            // master nacks the single byte, result stays in shift_byte
            nxt.last_status = ST_OK;
            nxt.phase       = PH_STOP_LOW;
          end
          PH_STOP_LOW:  nxt.phase = PH_STOP_HIGH;
          PH_STOP_HIGH: nxt.phase = PH_STOP_END;
          PH_STOP_END: begin
            nxt.phase = PH_IDLE;
            done      = 1'b1;
          end
          default: nxt.phase = PH_IDLE;
        endcase
      end
    end
  end

  // bus levels follow the state after the tick
  always_comb begin
    case (nxt.phase)
      PH_START: begin
        res.scl_release = 1'b1;
        res.sda_release = 1'b0;
      end
      PH_TX_LOW: begin
        res.scl_release = 1'b0;
        res.sda_release = nxt.shift_byte[7];
      end
      PH_TX_HIGH: begin
        res.scl_release = 1'b1;
        res.sda_release = nxt.shift_byte[7];
      end
      PH_TACK_LOW, PH_RX_LOW, PH_RACK_LOW: begin
        res.scl_release = 1'b0;
        res.sda_release = 1'b1;
      end
      PH_STOP_LOW: begin
        res.scl_release = 1'b0;
        res.sda_release = 1'b0;
      end
      PH_STOP_HIGH: begin
        res.scl_release = 1'b1;
        res.sda_release = 1'b0;
      end
      default: begin
        res.scl_release = 1'b1;
        res.sda_release = 1'b1;
      end
    endcase
    busy          = (nxt.phase != PH_IDLE);
    res.busy_res  = busy;
    res.done_res  = done;
    res.status    = busy ? ST_OK : nxt.last_status;
    res.read_data = busy ? 8'd0 : nxt.shift_byte;
  end

endmodule

// ----- rtl/i2c_master_transaction_engine_core.sv -----
// Tick-driven I2C master. Every transaction on in_if is one bus tick carrying the
// sampled SDA/SCL levels and an optional request (read one byte, write one or two
// bytes); every tick yields exactly one transaction on out_if with the open-drain
// release levels, busy/done flags and, when idle, the last status and read byte.
// One tick is taken per clock cycle while out_if backpressure does not stall
// the input; the tick passes an input register and then a result register
// before its result is offered on out_if, and that backpressure stalls the
// input only once both registers are full. SCL phase length is half_period_ticks
// (APB word 0, zero acts as one); write it only while the engine is idle.
module i2c_master_transaction_engine_core
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  i2cm_in_if.sink     in_if,
  i2cm_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        s1_valid_r;
  tick_item_t  s1_item_r;
  eng_state_t  state_r;
  eng_state_t  state_nxt;
  tick_res_t   res_nxt;
  tick_res_t   out_res_r;
  logic        out_valid_r;
  logic [15:0] half_r;
  logic        advance;
  logic        cfg_hit;

  assign advance = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;

  i2cm_step u_step (
    .cur         (state_r),
    .item        (s1_item_r),
    .half_period (half_r),
    .nxt         (state_nxt),
    .res         (res_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_item_r <= '{req_valid:   in_if.req_valid,
                     req_type:    in_if.req_type,
                     dev_addr:    in_if.dev_addr,
                     data_first:  in_if.data_first,
                     data_second: in_if.data_second,
                     sda_in:      in_if.sda_in,
                     scl_in:      in_if.scl_in};
    end
  end

  // engine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, default: '0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.scl_release = out_res_r.scl_release;
  assign out_if.sda_release = out_res_r.sda_release;
  assign out_if.busy_res    = out_res_r.busy_res;
  assign out_if.done_res    = out_res_r.done_res;
  assign out_if.status      = out_res_r.status;
  assign out_if.read_data   = out_res_r.read_data;

  // configuration port
  assign cfg_hit = (paddr == {CFG_HALF_PERIOD, 2'b00});
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_RESET;
    end else if (psel && penable && pwrite && cfg_hit) begin
      half_r <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = cfg_hit ? {16'd0, half_r} : 32'd0;
  end

  // checks
  logic [15:0] h_eff;
  assign h_eff = (half_r == 16'd0) ? 16'd1 : half_r;

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_IDLE |-> state_r.tick_count == 16'd0)
    else $error("tick count left nonzero in idle");

  a_count_below_half: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.tick_count < h_eff)
    else $error("tick count reached half period");

  a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bit_count <= BITS_PER_BYTE)
    else $error("bit count past one byte");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.busy_res == (state_r.phase != PH_IDLE))
    else $error("held result out of step with engine state");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.done_res |=> state_r.phase == PH_IDLE && out_valid_r)
    else $error("done without return to idle");

endmodule
